>>> hw/rtl/rpr_pkg.sv
// ----------------------------------------------------------------------------
// rpr_pkg
// shared types and constants of the rotary position rotate unit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rpr_pkg;

    localparam int MAX_POSITIONS_DEF  = 256;
    localparam int PAIRS_PER_HEAD_DEF = 32;

    localparam int POS_W    = 8;
    localparam int PAIR_W   = 5;
    localparam int VAL_W    = 16;
    localparam int WORD_W   = 16;
    localparam int FRAC_BITS = 14;

    localparam int PROD_W  = VAL_W + WORD_W;
    localparam int SUM_W   = PROD_W + 2;
    localparam int SHIFT_W = SUM_W - FRAC_BITS;

    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 32;

    localparam logic KIND_LOAD   = 1'b0;
    localparam logic KIND_ROTATE = 1'b1;

    localparam logic signed [VAL_W-1:0] OUT_MAX = 16'sh7fff;
    localparam logic signed [VAL_W-1:0] OUT_MIN = 16'sh8000;

    typedef struct packed {
        logic valid;
        logic in_range;
    } rpr_ctl_t;

endpackage

`default_nettype wire

>>> hw/rtl/rpr_table.sv
// ----------------------------------------------------------------------------
// rpr_table
// cosine and sine table memory with registered read, row by position
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rpr_table import rpr_pkg::*; #(
    parameter int MAX_POSITIONS  = MAX_POSITIONS_DEF,
    parameter int PAIRS_PER_HEAD = PAIRS_PER_HEAD_DEF
) (
    input  wire logic                     aclk,
    input  wire logic                     advance,
    input  wire logic                     load_en,
    input  wire logic [POS_W-1:0]         position,
    input  wire logic [PAIR_W-1:0]        pair_index,
    input  wire logic signed [WORD_W-1:0] cos_word,
    input  wire logic signed [WORD_W-1:0] sin_word,
    output logic signed [WORD_W-1:0]      cos_q,
    output logic signed [WORD_W-1:0]      sin_q,
    output logic                          in_range_q
);

    localparam int DEPTH  = MAX_POSITIONS * PAIRS_PER_HEAD;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PW     = (PAIRS_PER_HEAD > 1) ? $clog2(PAIRS_PER_HEAD) : 1;
    localparam int IDX_W  = AW + POS_W + PW;
    localparam int PAIR_SPAN = 2 ** PAIR_W;

    logic [2*WORD_W-1:0] mem [DEPTH];
    logic [PW-1:0]       pair_mod_lut [PAIR_SPAN];
    logic [IDX_W-1:0]    idx_wide;
    logic [AW-1:0]       addr;
    logic                in_range;
    logic [2*WORD_W-1:0] rd_reg;
    logic                in_range_reg;

    // pair index folded into one head
    for (genvar gi = 0; gi < PAIR_SPAN; gi++) begin : g_pair_mod
        assign pair_mod_lut[gi] = PW'(gi % PAIRS_PER_HEAD);
    end

    assign in_range = (IDX_W'(position) < IDX_W'(MAX_POSITIONS));
    assign idx_wide = IDX_W'(position) * IDX_W'(PAIRS_PER_HEAD)
                    + IDX_W'(pair_mod_lut[pair_index]);
    assign addr     = idx_wide[AW-1:0];

    always_ff @(posedge aclk) begin
        if (load_en && in_range) begin
            mem[addr] <= {sin_word, cos_word};
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            rd_reg       <= mem[addr];
            in_range_reg <= in_range;
        end
    end

    assign cos_q      = rd_reg[WORD_W-1:0];
    assign sin_q      = rd_reg[2*WORD_W-1:WORD_W];
    assign in_range_q = in_range_reg;

endmodule

`default_nettype wire

>>> hw/rtl/rpr_math.sv
// ----------------------------------------------------------------------------
// rpr_math
// product stage, then round, clamp and result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rpr_math import rpr_pkg::*; (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     advance,
    input  wire rpr_ctl_t                 ctl_in,
    input  wire logic signed [VAL_W-1:0]  x_val,
    input  wire logic signed [VAL_W-1:0]  y_val,
    input  wire logic signed [WORD_W-1:0] cos_val,
    input  wire logic signed [WORD_W-1:0] sin_val,
    output rpr_ctl_t                      ctl_out,
    output logic signed [VAL_W-1:0]       rot_first,
    output logic signed [VAL_W-1:0]       rot_second,
    output logic                          sat
);

    rpr_ctl_t                   ctl2_reg;
    logic signed [PROD_W-1:0]   xc_reg, ys_reg, xs_reg, yc_reg;
    rpr_ctl_t                   ctl3_reg;
    logic signed [VAL_W-1:0]    first_reg, second_reg;
    logic                       sat_reg;

    logic signed [SUM_W-1:0]    sum_a, sum_b;
    logic signed [SHIFT_W-1:0]  sh_a, sh_b;
    logic signed [VAL_W-1:0]    first_next, second_next;
    logic                       clamp_a, clamp_b;

    always_ff @(posedge aclk) begin
        if (advance) begin
            xc_reg <= x_val * cos_val;
            ys_reg <= y_val * sin_val;
            xs_reg <= x_val * sin_val;
            yc_reg <= y_val * cos_val;
        end
    end

    assign sum_a = SUM_W'(xc_reg) - SUM_W'(ys_reg) + SUM_W'(1 << (FRAC_BITS - 1));
    assign sum_b = SUM_W'(xs_reg) + SUM_W'(yc_reg) + SUM_W'(1 << (FRAC_BITS - 1));
    assign sh_a  = SHIFT_W'(sum_a >>> FRAC_BITS);
    assign sh_b  = SHIFT_W'(sum_b >>> FRAC_BITS);

    always_comb begin
        clamp_a = 1'b1;
        clamp_b = 1'b1;
        if (sh_a > SHIFT_W'(OUT_MAX)) begin
            first_next = OUT_MAX;
        end else if (sh_a < SHIFT_W'(OUT_MIN)) begin
            first_next = OUT_MIN;
        end else begin
            first_next = sh_a[VAL_W-1:0];
            clamp_a    = 1'b0;
        end
        if (sh_b > SHIFT_W'(OUT_MAX)) begin
            second_next = OUT_MAX;
        end else if (sh_b < SHIFT_W'(OUT_MIN)) begin
            second_next = OUT_MIN;
        end else begin
            second_next = sh_b[VAL_W-1:0];
            clamp_b     = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            ctl3_reg.in_range <= ctl2_reg.in_range;
            ctl2_reg.in_range <= ctl_in.in_range;
            // rows past the table answer with all fields zero
            if (ctl2_reg.in_range) begin
                first_reg  <= first_next;
                second_reg <= second_next;
                sat_reg    <= clamp_a | clamp_b;
            end else begin
                first_reg  <= '0;
                second_reg <= '0;
                sat_reg    <= 1'b0;
            end
        end
        if (!aresetn) begin
            ctl2_reg.valid <= 1'b0;
            ctl3_reg.valid <= 1'b0;
        end else if (advance) begin
            ctl2_reg.valid <= ctl_in.valid;
            ctl3_reg.valid <= ctl2_reg.valid;
        end
    end

    assign ctl_out    = ctl3_reg;
    assign rot_first  = first_reg;
    assign rot_second = second_reg;
    assign sat        = sat_reg;

endmodule

`default_nettype wire

>>> hw/rtl/rotary_position_rotate_top.sv
// ----------------------------------------------------------------------------
// rotary_position_rotate_top
// rotary position embedding: table load and pair rotation on one stream
// ----------------------------------------------------------------------------
// channel   dir   tdata                                   tuser
// s_        in    position, pair_index, first, second,    kind
//                 cos_word, sin_word
// m_        out   rotated_first, rotated_second           saturated
//
// one transfer per cycle on each side while the output is not stalled; a rotate
// result passes the registered stages table read, products, round and clamp
// load transfers write the table at once and give no result
// the table memory is not cleared by reset; only the stage valids are
// the whole pipeline holds while the result register is full and not taken
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rotary_position_rotate_top import rpr_pkg::*; #(
    parameter int MAX_POSITIONS  = MAX_POSITIONS_DEF,
    parameter int PAIRS_PER_HEAD = PAIRS_PER_HEAD_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // position[7:0] pair_index[12:8] first_value[28:13] second_value[44:29]
    // cos_word[60:45] sin_word[76:61], zero fill up to 80 bits
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    // kind
    input  wire logic                 s_tuser,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // rotated_first[15:0] rotated_second[31:16]
    output logic [M_TDATA_W-1:0]      m_tdata,
    // saturated
    output logic                      m_tuser
);

    logic                     advance;
    logic                     s_xfer;
    logic [POS_W-1:0]         position;
    logic [PAIR_W-1:0]        pair_index;
    logic signed [VAL_W-1:0]  first_value, second_value;
    logic signed [WORD_W-1:0] cos_word, sin_word;

    logic signed [WORD_W-1:0] cos_q, sin_q;
    logic                     in_range_q;
    logic                     valid1_reg;
    logic signed [VAL_W-1:0]  x1_reg, y1_reg;
    rpr_ctl_t                 ctl1;
    rpr_ctl_t                 ctl_out;
    logic signed [VAL_W-1:0]  rot_first, rot_second;
    logic                     sat;

    assign position     = s_tdata[7:0];
    assign pair_index   = s_tdata[12:8];
    assign first_value  = s_tdata[28:13];
    assign second_value = s_tdata[44:29];
    assign cos_word     = s_tdata[60:45];
    assign sin_word     = s_tdata[76:61];

    assign advance  = !ctl_out.valid || m_tready;
    assign s_tready = advance && aresetn;
    assign s_xfer   = s_tvalid && s_tready;

    rpr_table #(
        .MAX_POSITIONS  (MAX_POSITIONS),
        .PAIRS_PER_HEAD (PAIRS_PER_HEAD)
    ) u_table (
        .aclk       (aclk),
        .advance    (advance),
        .load_en    (s_xfer && (s_tuser == KIND_LOAD)),
        .position   (position),
        .pair_index (pair_index),
        .cos_word   (cos_word),
        .sin_word   (sin_word),
        .cos_q      (cos_q),
        .sin_q      (sin_q),
        .in_range_q (in_range_q)
    );

    always_ff @(posedge aclk) begin
        if (advance) begin
            x1_reg <= first_value;
            y1_reg <= second_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid1_reg <= 1'b0;
        end else if (advance) begin
            valid1_reg <= s_xfer && (s_tuser == KIND_ROTATE);
        end
    end

    assign ctl1.valid    = valid1_reg;
    assign ctl1.in_range = in_range_q;

    rpr_math u_math (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .advance    (advance),
        .ctl_in     (ctl1),
        .x_val      (x1_reg),
        .y_val      (y1_reg),
        .cos_val    (cos_q),
        .sin_val    (sin_q),
        .ctl_out    (ctl_out),
        .rot_first  (rot_first),
        .rot_second (rot_second),
        .sat        (sat)
    );

    assign m_tvalid = ctl_out.valid;
    assign m_tdata  = {rot_second, rot_first};
    assign m_tuser  = sat;

    a_rotate_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tuser == KIND_ROTATE)) |=> valid1_reg)
        else $error("rotate transfer did not enter the pipeline");

    a_load_no_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tuser == KIND_LOAD)) |=> !valid1_reg)
        else $error("load transfer entered the result pipeline");

    a_out_of_range_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !ctl_out.in_range) |-> (m_tdata == '0 && !m_tuser))
        else $error("out of range rotate gave nonzero result");

    a_sat_clamped: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (rot_first == OUT_MAX || rot_first == OUT_MIN
                                   || rot_second == OUT_MAX || rot_second == OUT_MIN))
        else $error("saturation flag without a clamped value");

    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("pipeline advanced while result was stalled");

endmodule

`default_nettype wire

>>> bench/rotary_position_rotate_checker.sv
// ----------------------------------------------------------------------------
// rotary_position_rotate_checker
// watches both stream channels of the rotary position rotate unit, keeps its
// own copy of the cosine and sine tables, works out the rotated pair for each
// rotate transfer and compares every result transfer against it in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rotary_position_rotate_checker import rpr_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 s_tuser,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,
    input  logic                 m_tuser,
    output int                   mismatches,
    output int                   pending
);

    localparam int ENTRIES = MAX_POSITIONS_DEF * PAIRS_PER_HEAD_DEF;
    localparam int PAIR_LO = POS_W;
    localparam int X_LO    = PAIR_LO + PAIR_W;
    localparam int Y_LO    = X_LO + VAL_W;
    localparam int COS_LO  = Y_LO + VAL_W;
    localparam int SIN_LO  = COS_LO + WORD_W;

    typedef struct packed {
        logic [VAL_W-1:0] first;
        logic [VAL_W-1:0] second;
        logic             saturated;
    } rotated_pair_t;

    logic [WORD_W-1:0] cos_words [ENTRIES];
    logic [WORD_W-1:0] sin_words [ENTRIES];
    rotated_pair_t     rotated_pairs [$];

    initial begin
        mismatches = 0;
        pending    = 0;
    end

    // round to nearest, ties up, then clamp; top bit flags a clamp
    function automatic logic [VAL_W:0] round_sat(input longint sum);
        longint r;
        r = (sum + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
        if (r > longint'(OUT_MAX)) begin
            return {1'b1, OUT_MAX};
        end
        if (r < longint'(OUT_MIN)) begin
            return {1'b1, OUT_MIN};
        end
        return {1'b0, r[VAL_W-1:0]};
    endfunction

    function automatic rotated_pair_t rotate_pair(
        input logic signed [VAL_W-1:0]  x,
        input logic signed [VAL_W-1:0]  y,
        input logic signed [WORD_W-1:0] c,
        input logic signed [WORD_W-1:0] s
    );
        rotated_pair_t   r;
        logic [VAL_W:0]  a;
        logic [VAL_W:0]  b;
        a = round_sat(longint'(x) * longint'(c) - longint'(y) * longint'(s));
        b = round_sat(longint'(x) * longint'(s) + longint'(y) * longint'(c));
        r.first     = a[VAL_W-1:0];
        r.second    = b[VAL_W-1:0];
        r.saturated = a[VAL_W] | b[VAL_W];
        return r;
    endfunction

    always @(posedge aclk) begin
        int            pos;
        int            idx;
        rotated_pair_t want;
        rotated_pair_t got;
        if (!aresetn) begin
            rotated_pairs.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got.first     = m_tdata[VAL_W-1:0];
                got.second    = m_tdata[2*VAL_W-1:VAL_W];
                got.saturated = m_tuser;
                if (rotated_pairs.size() == 0) begin
                    mismatches++;
                    $display("%0t unexpected result: expected none, got %0d %0d sat %0b",
                             $time, $signed(got.first), $signed(got.second),
                             got.saturated);
                end else begin
                    want = rotated_pairs.pop_front();
                    if (got.first !== want.first || got.second !== want.second ||
                        got.saturated !== want.saturated) begin
                        mismatches++;
                        $display("%0t mismatch: expected %0d %0d sat %0b, got %0d %0d sat %0b",
                                 $time, $signed(want.first), $signed(want.second),
                                 want.saturated, $signed(got.first),
                                 $signed(got.second), got.saturated);
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                pos = s_tdata[POS_W-1:0];
                idx = pos * PAIRS_PER_HEAD_DEF
                      + int'(s_tdata[X_LO-1:PAIR_LO]) % PAIRS_PER_HEAD_DEF;
                if (s_tuser == KIND_LOAD) begin
                    if (pos < MAX_POSITIONS_DEF) begin
                        cos_words[idx] = s_tdata[SIN_LO-1:COS_LO];
                        sin_words[idx] = s_tdata[SIN_LO+WORD_W-1:SIN_LO];
                    end
                end else if (pos >= MAX_POSITIONS_DEF) begin
                    rotated_pairs.push_back('0);
                end else begin
                    rotated_pairs.push_back(rotate_pair(s_tdata[Y_LO-1:X_LO],
                                                        s_tdata[COS_LO-1:Y_LO],
                                                        cos_words[idx],
                                                        sin_words[idx]));
                end
            end
        end
        pending = rotated_pairs.size();
    end

endmodule

>>> bench/rotary_position_rotate_top_tb.sv
// ----------------------------------------------------------------------------
// rotary_position_rotate_top_tb
// drives table loads and pair rotations into the rotary position rotate unit
// with random sender gaps and receiver stalls; a separate checker predicts
// and compares every result, and this top gives the verdict
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rotary_position_rotate_top_tb;

    import rpr_pkg::*;

    localparam int ENTRIES     = MAX_POSITIONS_DEF * PAIRS_PER_HEAD_DEF;
    localparam int CYCLE_LIMIT = 200000;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;
    logic                 s_took = 1'b0;

    int mismatches;
    int pending;
    int cycle_count     = 0;
    int send_gap_pct    = 0;
    int recv_stall_pct  = 0;
    int recv_stall_left = 0;

    bit loaded [ENTRIES];
    int loaded_entries [$];

    rotary_position_rotate_top DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    rotary_position_rotate_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .mismatches (mismatches),
        .pending    (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        s_took      <= s_tvalid && s_tready;
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // random receiver stall bursts
    always @(negedge aclk) begin
        if (recv_stall_left > 0) begin
            recv_stall_left <= recv_stall_left - 1;
            m_tready        <= 1'b0;
        end else if (recv_stall_pct > 0 && $urandom_range(0, 99) < recv_stall_pct) begin
            recv_stall_left <= $urandom_range(0, 10);
            m_tready        <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic send_item(
        input logic              kind,
        input logic [POS_W-1:0]  pos,
        input logic [PAIR_W-1:0] pair,
        input logic [VAL_W-1:0]  x,
        input logic [VAL_W-1:0]  y,
        input logic [WORD_W-1:0] c,
        input logic [WORD_W-1:0] s
    );
        int idx;
        if (send_gap_pct > 0 && $urandom_range(0, 99) < send_gap_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge aclk);
        end
        s_tdata  <= {{(S_TDATA_W - POS_W - PAIR_W - 2*VAL_W - 2*WORD_W){1'b0}},
                     s, c, y, x, pair, pos};
        s_tuser  <= kind;
        s_tvalid <= 1'b1;
        do @(negedge aclk); while (!s_took);
        idx = {pos, pair};
        if (kind == KIND_LOAD && !loaded[idx]) begin
            loaded[idx] = 1'b1;
            loaded_entries.push_back(idx);
        end
    endtask

    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 15))
            0:       return 16'h7fff;
            1:       return 16'h8000;
            2:       return 16'h0000;
            3:       return 16'hffff;
            default: return VAL_W'($urandom);
        endcase
    endfunction

    function automatic logic [WORD_W-1:0] pick_word();
        if ($urandom_range(0, 3) == 0) begin
            return WORD_W'($urandom);
        end
        return WORD_W'($urandom_range(0, 32768) - 16384);
    endfunction

    task automatic run_phase(input int count, input int gap_pct, input int stall_pct);
        int idx;
        send_gap_pct   = gap_pct;
        recv_stall_pct = stall_pct;
        repeat (count) begin
            if (loaded_entries.size() == 0 || $urandom_range(0, 99) < 25) begin
                send_item(KIND_LOAD, POS_W'($urandom), PAIR_W'($urandom),
                          VAL_W'($urandom), VAL_W'($urandom), pick_word(), pick_word());
            end else begin
                idx = loaded_entries[$urandom_range(0, loaded_entries.size() - 1)];
                send_item(KIND_ROTATE, idx[12:5], idx[4:0], pick_value(), pick_value(),
                          WORD_W'($urandom), WORD_W'($urandom));
            end
        end
    endtask

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tuser  = KIND_LOAD;
        s_tdata  = '0;
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: table extremes, rounding ties, saturation, overwrite
        send_item(KIND_LOAD,     0,  0, 0, 0, 16'sd16384, 16'sd0);
        send_item(KIND_LOAD,   255, 31, 0, 0, -16'sd16384, 16'sd16384);
        send_item(KIND_LOAD,     1,  5, 0, 0, 16'h7fff, 16'h8000);
        send_item(KIND_LOAD,     2,  7, 0, 0, 16'h8000, 16'h8000);
        send_item(KIND_LOAD,     3,  0, 0, 0, 16'h0000, 16'h0000);
        send_item(KIND_LOAD,     4,  1, 0, 0, 16'sd1, 16'sd0);
        send_item(KIND_ROTATE,   0,  0, 16'h7fff, 16'h8000, 0, 0);
        send_item(KIND_ROTATE, 255, 31, 16'h8000, 16'h8000, 0, 0);
        send_item(KIND_ROTATE, 255, 31, 16'sd12345, -16'sd321, 0, 0);
        send_item(KIND_ROTATE,   1,  5, 16'h7fff, 16'h7fff, 0, 0);
        send_item(KIND_ROTATE,   1,  5, 16'h8000, 16'h0000, 0, 0);
        send_item(KIND_ROTATE,   2,  7, 16'h8000, 16'h8000, 0, 0);
        send_item(KIND_ROTATE,   3,  0, 16'hffff, 16'sd1, 0, 0);
        send_item(KIND_ROTATE,   4,  1, 16'sd8192, 16'sd0, 0, 0);
        send_item(KIND_ROTATE,   4,  1, -16'sd8192, 16'sd0, 0, 0);
        send_item(KIND_ROTATE,   4,  1, -16'sd8193, 16'sd0, 0, 0);
        send_item(KIND_ROTATE,   4,  1, 16'sd24576, 16'sd0, 0, 0);
        send_item(KIND_LOAD,     0,  0, 0, 0, 16'sd0, 16'sd16384);
        send_item(KIND_ROTATE,   0,  0, 16'sd100, 16'sd200, 0, 0);
        send_item(KIND_LOAD,   128, 16, 0, 0, 16'sd11585, 16'sd11585);
        send_item(KIND_ROTATE, 128, 16, 16'sd1000, -16'sd1000, 0, 0);

        run_phase(150, 20, 20);
        run_phase(130, 0, 40);
        run_phase(130, 50, 0);
        run_phase(120, 0, 0);
        s_tvalid <= 1'b0;

        while (pending != 0) @(negedge aclk);
        repeat (12) @(negedge aclk);
        if (mismatches == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
